>>> src/sha1c_pkg.sv
// Shared types, constants and helpers for the SHA-1 block compression unit.
// Depends on nothing; every other file of the unit imports it.
package sha1c_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [4:0] chain_type;

   localparam int unsigned NumChain   = 5;
   localparam int unsigned NumSched   = 16;
   localparam int unsigned NumRounds  = 80;

   localparam logic [2:0] LastChainIdx = 3'd4;
   localparam logic [3:0] LastMsgIdx   = 4'd15;
   localparam logic [6:0] LastRound    = 7'd79;

   // Round groups of twenty rounds each.
   typedef enum logic [1:0] {
      PH_CHOOSE = 2'd0,
      PH_PARITY_A = 2'd1,
      PH_MAJORITY = 2'd2,
      PH_PARITY_B = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam logic KIND_CHAIN = 1'b0;
   localparam logic KIND_MSG   = 1'b1;

   localparam word_type ROUND_K0 = 32'h5A82_7999;
   localparam word_type ROUND_K1 = 32'h6ED9_EBA1;
   localparam word_type ROUND_K2 = 32'h8F1B_BCDC;
   localparam word_type ROUND_K3 = 32'hCA62_C1D6;

   typedef struct packed {
      logic      load;
      logic      step;
      phase_type phase;
   } round_ctrl_type;

   typedef struct packed {
      logic push;
      logic step;
   } sched_ctrl_type;

   function automatic phase_type round_phase(input logic [6:0] rnd);
      phase_type ph;
      if (rnd < 7'd20) begin
         ph = PH_CHOOSE;
      end else if (rnd < 7'd40) begin
         ph = PH_PARITY_A;
      end else if (rnd < 7'd60) begin
         ph = PH_MAJORITY;
      end else begin
         ph = PH_PARITY_B;
      end
      return ph;
   endfunction

endpackage

>>> src/sha1c_schedule.sv
// Sixteen-word sliding message schedule window of the SHA-1 unit.
// Depends on sha1c_pkg for the word type and the control struct.
module sha1c_schedule import sha1c_pkg::*; (
   input  logic           clock,
   input  sched_ctrl_type ctrl,
   input  word_type       msg_word,
   output word_type       wt
);

   word_type window_ff [NumSched];
   word_type window_in [NumSched];
   word_type expand;

   // window_ff[0] holds W[t]; the next expanded word is W[t+16].
   assign expand = window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0];
   assign wt     = window_ff[0];

   always_comb begin
      for (int i = 0; i < NumSched - 1; i++) begin
         window_in[i] = window_ff[i + 1];
      end
      if (ctrl.push) begin
         window_in[NumSched - 1] = msg_word;
      end else begin
         window_in[NumSched - 1] = {expand[30:0], expand[31]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push || ctrl.step) begin
         window_ff <= window_in;
      end
   end

endmodule

>>> src/sha1c_round.sv
// Working registers a to e and the shared round datapath of the SHA-1 unit.
// Depends on sha1c_pkg for the word types, round constants and control struct.
module sha1c_round import sha1c_pkg::*; (
   input  logic           clock,
   input  round_ctrl_type ctrl,
   input  chain_type      chain,
   input  word_type       wt,
   output chain_type      work
);

   chain_type work_ff;
   chain_type work_in;
   word_type  a, b, c, d, e;
   word_type  f, k, tmp;

   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];

   always_comb begin
      unique case (ctrl.phase)
         PH_CHOOSE: begin
            f = (b & c) | (~b & d);
            k = ROUND_K0;
         end
         PH_PARITY_A: begin
            f = b ^ c ^ d;
            k = ROUND_K1;
         end
         PH_MAJORITY: begin
            f = (b & c) | (b & d) | (c & d);
            k = ROUND_K2;
         end
         default: begin
            f = b ^ c ^ d;
            k = ROUND_K3;
         end
      endcase
      tmp = {a[26:0], a[31:27]} + f + e + k + wt;
   end

   always_comb begin
      if (ctrl.load) begin
         work_in = chain;
      end else begin
         work_in[0] = tmp;
         work_in[1] = a;
         work_in[2] = {b[1:0], b[31:2]};
         work_in[3] = c;
         work_in[4] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load || ctrl.step) begin
         work_ff <= work_in;
      end
   end

   assign work = work_ff;

endmodule

>>> src/sha1_block_compress_unit.sv
// Top level of the SHA-1 block compression unit: sequencer, chaining words
// and result port. Depends on sha1c_pkg, sha1c_schedule and sha1c_round.
//
// Usage. The request channel (req_valid, req_ready, req_kind, req_data_word)
// carries one word per transaction. A transaction of kind 0 loads the next
// chaining word, in the order 0 to 4, wrapping after the fifth. A transaction
// of kind 1 appends the next big-endian message word. Loads and message words
// may be interleaved freely; they use independent counters.
// The sixteenth message word of a block starts the compression. The unit then
// runs the 80 rounds at one round per cycle through a single shared round
// datapath, adds the result to the chaining words in the fold state, and
// presents the five new chaining words on the response channel (rsp_valid,
// rsp_ready, rsp_out_index, rsp_digest_word, rsp_last_word), index 0 first,
// with rsp_last_word set on index 4.
// The first response is valid once the round states and the fold state have
// passed; the remaining four follow one per cycle if the receiver is ready.
// req_ready is high only while the unit is idle: it is low during the rounds,
// the final addition and until the last response transaction completes.
// When the receiver stalls, the current response simply holds.
// Reset (synchronous, active high) clears the chaining words and both counters
// and returns the sequencer to idle. The message window has no reset; a block
// only runs once sixteen fresh words have been written.
module sha1_block_compress_unit import sha1c_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_index,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_last_word
);

   state_type      state_ff, state_in;
   chain_type      chain_ff, chain_in;
   logic [2:0]     load_cnt_ff, load_cnt_in;
   logic [3:0]     word_cnt_ff, word_cnt_in;
   logic [6:0]     rnd_ff, rnd_in;
   logic [2:0]     emit_idx_ff, emit_idx_in;
   logic           req_fire, rsp_fire, block_done;
   round_ctrl_type round_ctrl;
   sched_ctrl_type sched_ctrl;
   word_type       wt;
   chain_type      work;

   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign block_done = req_fire && (req_kind == KIND_MSG) && (word_cnt_ff == LastMsgIdx);

   sha1c_schedule u_schedule (
      .clock    (clock),
      .ctrl     (sched_ctrl),
      .msg_word (req_data_word),
      .wt       (wt)
   );

   sha1c_round u_round (
      .clock (clock),
      .ctrl  (round_ctrl),
      .chain (chain_ff),
      .wt    (wt),
      .work  (work)
   );

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (block_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (rnd_ff == LastRound) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire && (emit_idx_ff == LastChainIdx)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output and control decode of the sequencer.
   always_comb begin
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      round_ctrl.load  = 1'b0;
      round_ctrl.step  = 1'b0;
      round_ctrl.phase = round_phase(rnd_ff);
      sched_ctrl.push  = 1'b0;
      sched_ctrl.step  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            sched_ctrl.push = req_valid && (req_kind == KIND_MSG);
            round_ctrl.load = block_done;
         end
         ST_ROUND: begin
            round_ctrl.step = 1'b1;
            sched_ctrl.step = 1'b1;
         end
         ST_FOLD: begin
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Counters and chaining words.
   always_comb begin
      chain_in    = chain_ff;
      load_cnt_in = load_cnt_ff;
      word_cnt_in = word_cnt_ff;
      rnd_in      = rnd_ff;
      emit_idx_in = emit_idx_ff;
      if (req_fire && (req_kind == KIND_CHAIN)) begin
         chain_in[load_cnt_ff] = req_data_word;
         load_cnt_in = (load_cnt_ff == LastChainIdx) ? 3'd0 : load_cnt_ff + 3'd1;
      end
      if (req_fire && (req_kind == KIND_MSG)) begin
         word_cnt_in = word_cnt_ff + 4'd1;
      end
      if (block_done) begin
         rnd_in = 7'd0;
      end else if (state_ff == ST_ROUND) begin
         rnd_in = rnd_ff + 7'd1;
      end
      if (state_ff == ST_FOLD) begin
         for (int i = 0; i < NumChain; i++) begin
            chain_in[i] = chain_ff[i] + work[i];
         end
         emit_idx_in = 3'd0;
      end else if (rsp_fire) begin
         emit_idx_in = emit_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chain_ff    <= '0;
         load_cnt_ff <= 3'd0;
         word_cnt_ff <= 4'd0;
         rnd_ff      <= 7'd0;
         emit_idx_ff <= 3'd0;
      end else begin
         state_ff    <= state_in;
         chain_ff    <= chain_in;
         load_cnt_ff <= load_cnt_in;
         word_cnt_ff <= word_cnt_in;
         rnd_ff      <= rnd_in;
         emit_idx_ff <= emit_idx_in;
      end
   end

   // Results come straight from the chaining registers.
   assign rsp_out_index   = emit_idx_ff;
   assign rsp_digest_word = chain_ff[emit_idx_ff];
   assign rsp_last_word   = (emit_idx_ff == LastChainIdx);

   // The unit never takes a request while a result is on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   // Completing a block closes the request channel on the next cycle.
   a_block_busy: assert property (@(posedge clock) disable iff (reset)
      block_done |=> !req_ready && (state_ff == ST_ROUND) && (rnd_ff == 7'd0))
      else $error("block completion did not start the rounds");

   // Round counter stays within the eighty rounds.
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (rnd_ff <= LastRound))
      else $error("round counter out of range");

   // After the last round the fold state comes directly before the first result.
   a_fold_then_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && (rnd_ff == LastRound) |=> !rsp_valid ##1
      (rsp_valid && (rsp_out_index == 3'd0)))
      else $error("results did not follow the fold cycle");

   // Delivering the final word returns the unit to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_last_word |=> req_ready && !rsp_valid)
      else $error("unit did not go idle after the last result");

endmodule

>>> test/sha1_block_compress_unit_tb.sv
// Self-checking testbench for sha1_block_compress_unit: chaining-word loads and
// message blocks, with every digest word checked against a predictor in this file.
// Depends on sha1c_pkg and the RTL of the unit; it reads and writes no files.
`timescale 1ns / 1ps

module sha1_block_compress_unit_tb import sha1c_pkg::*;;

   // One request transaction as queued by the stimulus builder. The traffic
   // phase selects the idling mix, and a drain flag makes the sender wait
   // until every outstanding digest word has been received.
   typedef struct {
      logic        kind;
      word_type    data;
      int unsigned phase;
      bit          drain;
   } word_item_type;

   typedef struct {
      logic [2:0] index;
      word_type   word;
      logic       last;
   } digest_entry_type;

   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned HoldCycles    = 250;
   localparam int unsigned SettleCycles  = 100;
   localparam int unsigned ReportLimit   = 10;
   localparam int unsigned RandomItems   = 196;

   localparam word_type Sha1K0 = 32'h5A82_7999;
   localparam word_type Sha1K1 = 32'h6ED9_EBA1;
   localparam word_type Sha1K2 = 32'h8F1B_BCDC;
   localparam word_type Sha1K3 = 32'hCA62_C1D6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_CHAIN;
   logic [31:0] req_data_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_out_index;
   logic [31:0] rsp_digest_word;
   logic        rsp_last_word;

   sha1_block_compress_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_data_word   (req_data_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_index   (rsp_out_index),
      .rsp_digest_word (rsp_digest_word),
      .rsp_last_word   (rsp_last_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: the unit's chaining words, the sixteen-word message
   // window and the two independent write positions.
   word_type    chain_state [5];
   word_type    msg_window [16];
   logic [2:0]  load_pos = '0;
   logic [3:0]  msg_pos = '0;

   word_item_type    word_q [$];
   digest_entry_type digest_q [$];

   int unsigned traffic_phase = 0;
   int unsigned mismatch_count = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned stall_cycles = 0;

   initial begin
      for (int i = 0; i < 5; i++) begin
         chain_state[i] = '0;
      end
      for (int i = 0; i < 16; i++) begin
         msg_window[i] = '0;
      end
   end

   // Eighty SHA-1 rounds over the message window, then the modulo 2^32
   // addition into the chaining words.
   function automatic void sha1_rounds();
      word_type w [16];
      word_type a, b, c, d, e, f, k, wt, tmp;
      for (int i = 0; i < 16; i++) begin
         w[i] = msg_window[i];
      end
      a = chain_state[0];
      b = chain_state[1];
      c = chain_state[2];
      d = chain_state[3];
      e = chain_state[4];
      for (int t = 0; t < NumRounds; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            wt = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
            wt = {wt[30:0], wt[31]};
            w[t % 16] = wt;
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = Sha1K0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = Sha1K1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = Sha1K2;
         end else begin
            f = b ^ c ^ d;
            k = Sha1K3;
         end
         tmp = {a[26:0], a[31:27]} + f + e + k + wt;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = tmp;
      end
      chain_state[0] += a;
      chain_state[1] += b;
      chain_state[2] += c;
      chain_state[3] += d;
      chain_state[4] += e;
   endfunction

   // Applies one accepted request transaction to the predictor and queues
   // the five digest words when it completes a block.
   function automatic void absorb_word(input logic kind, input word_type data);
      digest_entry_type entry;
      if (kind == KIND_CHAIN) begin
         chain_state[load_pos] = data;
         load_pos = (load_pos == LastChainIdx) ? 3'd0 : load_pos + 3'd1;
      end else begin
         msg_window[msg_pos] = data;
         if (msg_pos != LastMsgIdx) begin
            msg_pos = msg_pos + 4'd1;
         end else begin
            msg_pos = '0;
            sha1_rounds();
            for (int i = 0; i < 5; i++) begin
               entry.index = i[2:0];
               entry.word  = chain_state[i];
               entry.last  = (i == 4);
               digest_q.push_back(entry);
            end
         end
      end
   endfunction

   task automatic queue_word(input logic kind, input word_type data,
                             input int unsigned phase, input bit drain);
      word_item_type item;
      item.kind  = kind;
      item.data  = data;
      item.phase = phase;
      item.drain = drain;
      word_q.push_back(item);
   endtask

   // Driver. A transaction accepted at this edge goes to the predictor, and
   // the next one is offered unless the sender idles or must wait for a drain.
   always @(posedge clock) begin
      logic          next_valid;
      logic          next_kind;
      word_type      next_data;
      word_item_type item;
      int unsigned   gap_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_kind  = req_kind;
         next_data  = req_data_word;
         if (req_valid && req_ready) begin
            absorb_word(req_kind, req_data_word);
            next_valid = 1'b0;
         end
         if (!next_valid && word_q.size() != 0) begin
            gap_pct = (word_q[0].phase == 0) ? 6 : (word_q[0].phase == 1) ? 56 : 0;
            if (!(word_q[0].drain && digest_q.size() != 0) &&
                $urandom_range(0, 99) >= gap_pct) begin
               item       = word_q.pop_front();
               next_valid = 1'b1;
               next_kind  = item.kind;
               next_data  = item.data;
               traffic_phase <= item.phase;
            end
         end
         req_valid     <= next_valid;
         req_kind      <= next_kind;
         req_data_word <= next_data;
      end
   end

   // Monitor. Each response transaction is checked against the oldest
   // expectation; the ready line idles at random, and once in the last
   // phase it is held low for a long stretch so the unit backs up.
   always @(posedge clock) begin
      digest_entry_type want;
      logic             next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("%0t: unexpected response index %0d word %h last %b",
                           $realtime, rsp_out_index, rsp_digest_word, rsp_last_word);
               end
            end else begin
               want = digest_q.pop_front();
               if (rsp_out_index !== want.index || rsp_digest_word !== want.word ||
                   rsp_last_word !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= ReportLimit) begin
                     $display("%0t: expected index %0d word %h last %b, got %0d %h %b",
                              $realtime, want.index, want.word, want.last,
                              rsp_out_index, rsp_digest_word, rsp_last_word);
                  end
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (!hold_done && traffic_phase == 2 && rsp_valid) begin
            hold_left  = HoldCycles;
            hold_done  = 1'b1;
            next_ready = 1'b0;
         end else begin
            next_ready = $urandom_range(0, 99) >=
                         ((traffic_phase == 0) ? 56 : (traffic_phase == 1) ? 6 : 0);
         end
         rsp_ready <= next_ready;
      end
   end

   // Watchdog on cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WatchdogLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int unsigned random_count;
      int unsigned phase;
      int unsigned last_phase;
      int unsigned mode;
      bit          first;
      word_type    data;

      // Directed part. Seven loads run the load position round its wrap and
      // leave the usual SHA-1 initial values in place; the first two words
      // seen are the all-ones and all-zeros extremes.
      queue_word(KIND_CHAIN, 32'hFFFF_FFFF, 0, 1'b0);
      queue_word(KIND_CHAIN, 32'h0000_0000, 0, 1'b0);
      queue_word(KIND_CHAIN, 32'h98BA_DCFE, 0, 1'b0);
      queue_word(KIND_CHAIN, 32'h1032_5476, 0, 1'b0);
      queue_word(KIND_CHAIN, 32'hC3D2_E1F0, 0, 1'b0);
      queue_word(KIND_CHAIN, 32'h6745_2301, 0, 1'b0);
      queue_word(KIND_CHAIN, 32'hEFCD_AB89, 0, 1'b0);
      // The padded message "abc", with a load of chaining word 2 slipped in
      // between message words to show the two positions are independent.
      queue_word(KIND_MSG, 32'h6162_6380, 0, 1'b0);
      for (int i = 1; i < 15; i++) begin
         queue_word(KIND_MSG, 32'h0000_0000, 0, 1'b0);
         if (i == 3) begin
            queue_word(KIND_CHAIN, 32'h98BA_DCFE, 0, 1'b0);
         end
      end
      queue_word(KIND_MSG, 32'h0000_0018, 0, 1'b0);

      // Random part: mostly whole blocks that chain on from one another,
      // with loads sprinkled in, plus the odd run of loads alone.
      random_count = 0;
      last_phase   = 0;
      while (random_count < RandomItems) begin
         phase = (random_count * 3) / RandomItems;
         first = (phase != last_phase);
         last_phase = phase;
         mode = $urandom_range(0, 9);
         if (mode == 9) begin
            repeat ($urandom_range(1, 6)) begin
               queue_word(KIND_CHAIN, $urandom(), phase, first);
               first = 1'b0;
               random_count++;
            end
         end else begin
            for (int i = 0; i < 16; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  data = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom();
                  queue_word(KIND_CHAIN, data, phase, first);
                  first = 1'b0;
                  random_count++;
               end
               case (mode)
                  0: data = 32'hFFFF_FFFF;
                  1: data = 32'h0000_0000;
                  2: data = i[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
                  default: data = $urandom();
               endcase
               queue_word(KIND_MSG, data, phase, first);
               first = 1'b0;
               random_count++;
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (word_q.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (digest_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);

      if (mismatch_count == 0 && digest_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
